[src/prapq_pkg.sv]
package prapq_pkg;

	// request codes
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_ADD  = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;
	localparam logic [1:0] REQ_RSVD = 2'd3;

	// register index of size_in_use
	localparam logic REG_SIZE = 1'b0;

	typedef struct packed {
		logic [63:0] off;
		logic [63:0] stp;
	} tag_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_W_RD,
		ST_W_ADD,
		ST_W_MUL,
		ST_S_RD,
		ST_S_WR,
		ST_E_RD,
		ST_E_WR,
		ST_A_CHK,
		ST_A_UPD,
		ST_A_NEXT
	} state_t;

endpackage

[src/prapq_cfg.sv]
// size register, readback and clamp to the tree capacity
module prapq_cfg #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int PW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic [PW-1:0] eff_size
);

	localparam int CW = (PW > 11) ? PW : 11;

	logic [10:0] size_q;
	logic        sel_size;

	assign sel_size = (paddr[2] == prapq_pkg::REG_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 11'd1024;
		end else if (psel && penable && pwrite && sel_size) begin
			size_q <= pwdata[10:0];
		end
	end

	assign prdata = sel_size ? {21'd0, size_q} : 32'd0;

	always_comb begin
		if (CW'(size_q) > CW'(MAX_ELEMENTS)) begin
			eff_size = PW'(MAX_ELEMENTS);
		end else begin
			eff_size = PW'(size_q);
		end
	end

endmodule

[src/progression_range_add_point_query.sv]
// Progression range add / point query. Holds MAX_ELEMENTS signed 64-bit elements under a lazy
// segment tree whose nodes carry a pending arithmetic progression (offset, step); sums wrap
// modulo 2^64. One item at a time: in_ready is high only when the sequencer is idle. After
// reset a clearing pass writes every one of the 4*MAX_ELEMENTS tag entries before the first
// item is taken; configuration writes are taken meanwhile. A load or read walks root to leaf,
// at each tree level doing a tag read, sum, multiply, sibling read and sibling write, then a
// tag read and sum at the leaf and a write (load) or a read and write (read) at the element.
// An add goes through the tree depth first with a small stack: a partly covered node pushes
// its right half and descends left, a missed node pops the stack, and a covered node gets its
// tag updated before the pop. The tag memory is single-port, one access per cycle. Items that
// name an index outside 1..size_in_use, an empty add range or an unknown request are taken
// and dropped by the idle state with no result. A read result sits in an output register;
// the next item is taken while it waits, but a further read stalls at its end until the
// register is free.
module progression_range_add_point_query #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// request items
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   req_type,
	input  logic [10:0]  index_lo,
	input  logic [10:0]  index_hi,
	input  logic signed [63:0] load_value,
	// result items
	output logic         out_valid,
	input  logic         out_ready,
	output logic signed [63:0] read_value
);

	localparam int PW         = $clog2(MAX_ELEMENTS + 1);
	localparam int CW         = (PW > 11) ? PW : 11;
	localparam int TREE_NODES = 4 * MAX_ELEMENTS;
	localparam int NW         = $clog2(TREE_NODES);
	localparam int EAW        = $clog2(MAX_ELEMENTS);
	localparam int SD         = $clog2(MAX_ELEMENTS) + 2;
	localparam int SPW        = $clog2(SD + 1);

	prapq_pkg::state_t state_q, state_d;

	logic [PW-1:0] eff_size;

	// walk / sweep registers
	logic [NW-1:0]  node_q;
	logic [PW-1:0]  lo_q, hi_q, pos_q, mid_q, from_q, to_q;
	logic [NW-1:0]  clr_q;
	logic           is_read_q;
	logic [63:0]    val_q;
	logic [63:0]    c_off_q, c_stp_q;   // progression carried down the path
	logic [63:0]    t_off_q, t_stp_q;   // total tag of the current node
	logic [63:0]    prod_q;
	logic [63:0]    sib_off_q;
	logic [NW-1:0]  sib_q;
	logic [63:0]    next_q;             // first term for the next covered node

	// stack of right halves still to visit
	logic [NW-1:0]  stk_node_q [SD];
	logic [PW-1:0]  stk_lo_q   [SD];
	logic [PW-1:0]  stk_hi_q   [SD];
	logic [SPW-1:0] sp_q;

	// output register
	logic        out_valid_q;
	logic [63:0] out_value_q;
	logic        out_free;

	// memories
	prapq_pkg::tag_t tag_mem [TREE_NODES];
	prapq_pkg::tag_t tag_rd_q, tag_wd;
	logic [NW-1:0]   tag_addr;
	logic            tag_we;
	logic [63:0]     elem_mem [MAX_ELEMENTS];
	logic [63:0]     elem_rd_q, elem_wd;
	logic            elem_we;
	logic [EAW-1:0]  elem_addr;

	// decode of the offered item
	logic [CW-1:0] n_c, lo_c, hi_c;
	logic          pt_ok, add_ok;
	logic [PW:0]   mid_sum;
	logic [PW-1:0] mid_w;
	logic          leaf, disjoint, covered;
	logic [63:0]   sum_off, sum_stp;
	logic          accept;

	prapq_cfg #(.MAX_ELEMENTS(MAX_ELEMENTS), .PW(PW)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.eff_size(eff_size)
	);

	assign pready = 1'b1;

	assign n_c    = CW'(eff_size);
	assign lo_c   = CW'(index_lo);
	assign hi_c   = CW'(index_hi);
	assign pt_ok  = (lo_c != '0) && (lo_c <= n_c);
	assign add_ok = (lo_c != '0) && (lo_c <= hi_c) && (hi_c <= n_c);
	assign accept = in_valid && in_ready;

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w    = mid_sum[PW:1];
	assign leaf     = ((hi_q - lo_q) == PW'(1));
	assign disjoint = (to_q <= lo_q) || (hi_q <= from_q);
	assign covered  = (from_q <= lo_q) && (hi_q <= to_q);
	assign sum_off  = tag_rd_q.off + c_off_q;
	assign sum_stp  = tag_rd_q.stp + c_stp_q;
	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prapq_pkg::ST_CLR: begin
				if (clr_q == NW'(TREE_NODES - 1)) state_d = prapq_pkg::ST_IDLE;
			end
			prapq_pkg::ST_IDLE: begin
				if (accept) begin
					priority if ((req_type == prapq_pkg::REQ_LOAD
						|| req_type == prapq_pkg::REQ_READ) && pt_ok) begin
						state_d = prapq_pkg::ST_W_RD;
					end else if (req_type == prapq_pkg::REQ_ADD && add_ok) begin
						state_d = prapq_pkg::ST_A_CHK;
					end else begin
						state_d = prapq_pkg::ST_IDLE;
					end
				end
			end
			prapq_pkg::ST_W_RD:  state_d = prapq_pkg::ST_W_ADD;
			prapq_pkg::ST_W_ADD: begin
				if (!leaf)          state_d = prapq_pkg::ST_W_MUL;
				else if (is_read_q) state_d = prapq_pkg::ST_E_RD;
				else                state_d = prapq_pkg::ST_E_WR;
			end
			prapq_pkg::ST_W_MUL: state_d = prapq_pkg::ST_S_RD;
			prapq_pkg::ST_S_RD:  state_d = prapq_pkg::ST_S_WR;
			prapq_pkg::ST_S_WR:  state_d = prapq_pkg::ST_W_RD;
			prapq_pkg::ST_E_RD:  state_d = prapq_pkg::ST_E_WR;
			prapq_pkg::ST_E_WR: begin
				if (!is_read_q || out_free) state_d = prapq_pkg::ST_IDLE;
			end
			prapq_pkg::ST_A_CHK: begin
				priority if (disjoint)  state_d = prapq_pkg::ST_A_NEXT;
				else if (covered)       state_d = prapq_pkg::ST_A_UPD;
				else                    state_d = prapq_pkg::ST_A_CHK;
			end
			prapq_pkg::ST_A_UPD:  state_d = prapq_pkg::ST_A_NEXT;
			prapq_pkg::ST_A_NEXT: begin
				if (sp_q == '0) state_d = prapq_pkg::ST_IDLE;
				else            state_d = prapq_pkg::ST_A_CHK;
			end
			default: state_d = prapq_pkg::ST_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		in_ready  = 1'b0;
		tag_we    = 1'b0;
		tag_addr  = node_q;
		tag_wd    = '0;
		elem_we   = 1'b0;
		elem_addr = pos_q[EAW-1:0];
		elem_wd   = val_q;
		unique case (state_q)
			prapq_pkg::ST_CLR: begin
				tag_we   = 1'b1;
				tag_addr = clr_q;
			end
			prapq_pkg::ST_IDLE:  in_ready = 1'b1;
			prapq_pkg::ST_W_ADD: tag_we = 1'b1;     // tag moves down, node cleared
			prapq_pkg::ST_S_RD:  tag_addr = sib_q;
			prapq_pkg::ST_S_WR: begin
				tag_we     = 1'b1;
				tag_addr   = sib_q;
				tag_wd.off = tag_rd_q.off + sib_off_q;
				tag_wd.stp = tag_rd_q.stp + t_stp_q;
			end
			prapq_pkg::ST_E_WR: begin
				elem_we = !is_read_q || out_free;
				elem_wd = is_read_q ? (elem_rd_q + t_off_q) : val_q;
			end
			prapq_pkg::ST_A_UPD: begin
				tag_we     = 1'b1;
				tag_wd.off = tag_rd_q.off + next_q;
				tag_wd.stp = tag_rd_q.stp + 64'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[tag_addr] <= tag_wd;
		tag_rd_q <= tag_mem[tag_addr];
	end

	always_ff @(posedge clk) begin
		if (elem_we) elem_mem[elem_addr] <= elem_wd;
		elem_rd_q <= elem_mem[elem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= prapq_pkg::ST_CLR;
			clr_q       <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == prapq_pkg::ST_CLR) clr_q <= clr_q + NW'(1);
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == prapq_pkg::ST_E_WR && is_read_q && out_free) begin
				out_valid_q <= 1'b1;
			end
			if (state_q == prapq_pkg::ST_A_CHK && !disjoint && !covered) begin
				sp_q <= sp_q + SPW'(1);
			end else if (state_q == prapq_pkg::ST_A_NEXT && sp_q != '0) begin
				sp_q <= sp_q - SPW'(1);
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			prapq_pkg::ST_IDLE: begin
				node_q    <= NW'(1);
				lo_q      <= '0;
				hi_q      <= eff_size;
				pos_q     <= PW'(lo_c - CW'(1));
				from_q    <= PW'(lo_c - CW'(1));
				to_q      <= PW'(hi_c);
				is_read_q <= (req_type == prapq_pkg::REQ_READ);
				val_q     <= load_value;
				c_off_q   <= '0;
				c_stp_q   <= '0;
				next_q    <= 64'd1;
			end
			prapq_pkg::ST_W_ADD: begin
				t_off_q <= sum_off;
				t_stp_q <= sum_stp;
				mid_q   <= mid_w;
			end
			prapq_pkg::ST_W_MUL: begin
				prod_q <= t_stp_q * 64'(mid_q - lo_q);
			end
			prapq_pkg::ST_S_RD: ;
			prapq_pkg::ST_W_RD: ;
			prapq_pkg::ST_E_RD: ;
			prapq_pkg::ST_E_WR: begin
				if (is_read_q && out_free) out_value_q <= elem_wd;
			end
			prapq_pkg::ST_A_CHK: begin
				if (!disjoint && !covered) begin
					stk_node_q[sp_q[SPW-1:0]] <= {node_q[NW-2:0], 1'b1};
					stk_lo_q[sp_q[SPW-1:0]]   <= mid_w;
					stk_hi_q[sp_q[SPW-1:0]]   <= hi_q;
					node_q <= {node_q[NW-2:0], 1'b0};
					hi_q   <= mid_w;
				end
			end
			prapq_pkg::ST_A_UPD: begin
				next_q <= next_q + 64'(hi_q - lo_q);
			end
			prapq_pkg::ST_A_NEXT: begin
				if (sp_q != '0) begin
					node_q <= stk_node_q[sp_q - SPW'(1)];
					lo_q   <= stk_lo_q[sp_q - SPW'(1)];
					hi_q   <= stk_hi_q[sp_q - SPW'(1)];
				end
			end
			default: ;
		endcase
		// sibling selection and carry, one level per pass
		if (state_q == prapq_pkg::ST_W_MUL) begin
			if (pos_q < mid_q) sib_q <= {node_q[NW-2:0], 1'b1};
			else               sib_q <= {node_q[NW-2:0], 1'b0};
		end
		if (state_q == prapq_pkg::ST_S_RD) begin
			c_stp_q <= t_stp_q;
			if (pos_q < mid_q) begin
				sib_off_q <= t_off_q + prod_q;
				c_off_q   <= t_off_q;
				node_q    <= {node_q[NW-2:0], 1'b0};
				hi_q      <= mid_q;
			end else begin
				sib_off_q <= t_off_q;
				c_off_q   <= t_off_q + prod_q;
				node_q    <= {node_q[NW-2:0], 1'b1};
				lo_q      <= mid_q;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_value_q;

	a_clr_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prapq_pkg::ST_CLR |-> !in_ready)
		else $error("item taken during clearing pass");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SPW'(sp_q) <= SPW'(SD))
		else $error("range stack overflow");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prapq_pkg::ST_W_RD |-> (lo_q < hi_q) && (pos_q >= lo_q) && (pos_q < hi_q))
		else $error("walk left the path");

	a_node_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prapq_pkg::ST_W_ADD |-> tag_we && tag_wd == '0)
		else $error("visited node not cleared");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prapq_pkg::ST_E_WR && is_read_q && out_free |=> out_valid_q)
		else $error("read result lost");

endmodule

[test/tb_progression_range_add_point_query.sv]
module tb_progression_range_add_point_query;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ELEM   = 1024;
	localparam int NUM_NODES  = 4 * NUM_ELEM;
	localparam int IDLE_LIMIT = 20000;	// covers the tag clearing pass plus the long hold-off
	localparam int DRAIN_WAIT = 200;	// worst add/read latency with margin

	// Progression tree predictor: own copy of elements and per-node (offset, step) tags.
	class prog_tree_model;
		logic [63:0] elem [NUM_ELEM];
		bit          written [NUM_ELEM];
		logic [63:0] tag_off [NUM_NODES];
		logic [63:0] tag_stp [NUM_NODES];
		logic [63:0] next_term;
		int          n_eff;
		logic [63:0] expected_reads [$];
		int          errors;
		int          reads_checked;

		function new();
			foreach (tag_off[i]) begin
				tag_off[i] = '0;
				tag_stp[i] = '0;
			end
			foreach (elem[i]) begin
				elem[i]    = '0;
				written[i] = 0;
			end
			n_eff = NUM_ELEM;
		endfunction

		function void set_size(logic [10:0] v);
			n_eff = (int'(v) > NUM_ELEM) ? NUM_ELEM : int'(v);
		endfunction

		function void push_node(int node, int lo, int hi);
			logic [63:0] off, stp;
			int mid;
			if (node >= NUM_NODES) return;
			off = tag_off[node];
			stp = tag_stp[node];
			if (off == 0 && stp == 0) return;
			if (hi - lo == 1) begin
				if (lo < NUM_ELEM) elem[lo] += off;
			end else begin
				mid = (lo + hi) / 2;
				if (2 * node < NUM_NODES) begin
					tag_off[2 * node] += off;
					tag_stp[2 * node] += stp;
				end
				if (2 * node + 1 < NUM_NODES) begin
					tag_off[2 * node + 1] += off + 64'(mid - lo) * stp;
					tag_stp[2 * node + 1] += stp;
				end
			end
			tag_off[node] = '0;
			tag_stp[node] = '0;
		endfunction

		function void push_path(int node, int lo, int hi, int pos);
			int mid;
			if (pos < lo || pos >= hi || node >= NUM_NODES) return;
			push_node(node, lo, hi);
			if (hi - lo == 1) return;
			mid = (lo + hi) / 2;
			push_path(2 * node, lo, mid, pos);
			push_path(2 * node + 1, mid, hi, pos);
		endfunction

		function void tag_range(int node, int lo, int hi, int from, int to);
			int mid;
			if (to <= lo || hi <= from || node >= NUM_NODES) return;
			if (from <= lo && hi <= to) begin
				tag_off[node] += next_term;
				tag_stp[node] += 64'd1;
				next_term += 64'(hi - lo);
				return;
			end
			mid = (lo + hi) / 2;
			tag_range(2 * node, lo, mid, from, to);
			tag_range(2 * node + 1, mid, hi, from, to);
		endfunction

		function void note_request(logic [1:0] kind, logic [10:0] lo, logic [10:0] hi,
				logic [63:0] v);
			int l, h;
			l = int'(lo);
			h = int'(hi);
			case (kind)
				prapq_pkg::REQ_LOAD: begin
					if (l >= 1 && l <= n_eff) begin
						push_path(1, 0, n_eff, l - 1);
						elem[l - 1]    = v;
						written[l - 1] = 1;
					end
				end
				prapq_pkg::REQ_ADD: begin
					if (l <= h && l >= 1 && h <= n_eff) begin
						next_term = 64'd1;
						tag_range(1, 0, n_eff, l - 1, h);
					end
				end
				prapq_pkg::REQ_READ: begin
					if (l >= 1 && l <= n_eff) begin
						push_path(1, 0, n_eff, l - 1);
						expected_reads.push_back(elem[l - 1]);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_read(logic [63:0] got);
			logic [63:0] want;
			if (expected_reads.size() == 0) begin
				$display("%0t: unexpected read_value item %h", $time, got);
				errors++;
				return;
			end
			want = expected_reads.pop_front();
			reads_checked++;
			if (got !== want) begin
				$display("%0t: read_value mismatch, expected %h actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        in_valid, in_ready;
	logic [1:0]  req_type;
	logic [10:0] index_lo, index_hi;
	logic signed [63:0] load_value;
	logic        out_valid, out_ready;
	logic signed [63:0] read_value;

	prog_tree_model tree_model = new();

	int  items_sent;
	int  burst_left;
	int  idle_cycles = 0;
	bit  hold_done = 0;
	int  sizes_used [$];

	progression_range_add_point_query u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.index_lo   (index_lo),
		.index_hi   (index_hi),
		.load_value (load_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: any run that stops moving items for too long is a failure.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog, no item moved for %0d cycles", $time, IDLE_LIMIT);
			$display("tb_progression_range_add_point_query failed");
			$finish;
		end
	end

	// Result side: checks each accepted item, stalls in stretches of varying character,
	// and once holds off long enough for a second read to back up into the input.
	initial begin
		int stretch, mode;
		out_ready <= 1'b0;
		stretch = 0;
		mode    = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) tree_model.check_read(read_value);
			if (!hold_done && tree_model.reads_checked == 150) begin
				hold_done = 1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			if (stretch == 0) begin
				stretch = $urandom_range(1, 40);
				mode    = $urandom_range(0, 2);
			end
			stretch--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Register write: setup cycle, then access cycle; taken at the edge ending the access.
	task automatic write_size(logic [10:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(4 * prapq_pkg::REG_SIZE);
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tree_model.set_size(v);
		sizes_used.push_back(int'(v));
	endtask

	// Offers one request item and holds it until taken; bursts with random gaps between.
	task automatic send_item(logic [1:0] kind, logic [10:0] lo, logic [10:0] hi,
			logic [63:0] v);
		in_valid   <= 1'b1;
		req_type   <= kind;
		index_lo   <= lo;
		index_hi   <= hi;
		load_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tree_model.note_request(kind, lo, hi, v);
		items_sent++;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
								: $urandom_range(1, 15);
		end else begin
			burst_left--;
		end
	endtask

	// Block idle: no read pending, then let any trailing add or ignored item finish.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tree_model.expected_reads.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// One random request. Mostly well-formed traffic within the current size; the rest
	// is noise across the whole index space. Reads only ever hit loaded elements.
	task automatic random_item();
		int          n, r, l, h;
		logic [1:0]  kind;
		logic [63:0] v;
		n = tree_model.n_eff;
		r = $urandom_range(0, 99);
		v = {$urandom, $urandom};
		if (n == 0 || r < 10) begin
			kind = 2'($urandom_range(0, 3));
			l    = $urandom_range(0, 2047);
			h    = $urandom_range(0, 2047);
		end else if (r < 40) begin
			kind = prapq_pkg::REQ_LOAD;
			l    = $urandom_range(1, n);
			h    = $urandom_range(0, 2047);
		end else if (r < 70) begin
			kind = prapq_pkg::REQ_ADD;
			l    = $urandom_range(1, n);
			h    = ($urandom_range(0, 3) == 0) ? n : $urandom_range(l, n);
		end else begin
			kind = prapq_pkg::REQ_READ;
			l    = $urandom_range(1, n);
			h    = $urandom_range(0, 2047);
		end
		// never read an element that was never loaded
		if (kind == prapq_pkg::REQ_READ && l >= 1 && l <= n && !tree_model.written[l - 1])
			kind = prapq_pkg::REQ_LOAD;
		send_item(kind, 11'(l), 11'(h), v);
	endtask

	initial begin
		int sizes [$];
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		in_valid   <= 1'b0;
		req_type   <= prapq_pkg::REQ_LOAD;
		index_lo   <= '0;
		index_hi   <= '0;
		load_value <= '0;
		items_sent  = 0;
		burst_left  = 8;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// written while the tag clearing pass runs
		write_size(11'd1024);

		// directed: extremes, every request kind, empty and out-of-range cases
		send_item(prapq_pkg::REQ_LOAD, 11'd1,    11'd0, 64'h8000_0000_0000_0000);
		send_item(prapq_pkg::REQ_LOAD, 11'd1024, 11'd0, 64'h7fff_ffff_ffff_ffff);
		send_item(prapq_pkg::REQ_LOAD, 11'd512,  11'd0, 64'hffff_ffff_ffff_ffff);
		send_item(prapq_pkg::REQ_LOAD, 11'd513,  11'd0, 64'h0);
		send_item(prapq_pkg::REQ_ADD,  11'd1,    11'd1024, 64'h0);
		send_item(prapq_pkg::REQ_READ, 11'd1,    11'd0, 64'h0);
		send_item(prapq_pkg::REQ_READ, 11'd1024, 11'd0, 64'h0);
		send_item(prapq_pkg::REQ_READ, 11'd512,  11'd0, 64'h0);
		send_item(prapq_pkg::REQ_ADD,  11'd1,    11'd1, 64'h0);
		send_item(prapq_pkg::REQ_ADD,  11'd512,  11'd513, 64'h0);
		send_item(prapq_pkg::REQ_READ, 11'd513,  11'd0, 64'h0);
		send_item(prapq_pkg::REQ_ADD,  11'd5,    11'd4, 64'h0);		// empty range
		send_item(prapq_pkg::REQ_ADD,  11'd1,    11'd1025, 64'h0);	// beyond size
		send_item(prapq_pkg::REQ_ADD,  11'd0,    11'd2047, 64'h0);
		send_item(prapq_pkg::REQ_LOAD, 11'd0,    11'd0, 64'h1234);
		send_item(prapq_pkg::REQ_READ, 11'd0,    11'd0, 64'h0);
		send_item(prapq_pkg::REQ_READ, 11'd2047, 11'd2047, 64'hffff_ffff_ffff_ffff);
		send_item(prapq_pkg::REQ_RSVD, 11'd1,    11'd1, 64'h0);		// unknown request
		send_item(prapq_pkg::REQ_ADD,  11'd3,    11'd700, 64'h0);
		send_item(prapq_pkg::REQ_LOAD, 11'd600,  11'd0, 64'h0123_4567_89ab_cdef);
		send_item(prapq_pkg::REQ_READ, 11'd600,  11'd0, 64'h0);
		send_item(prapq_pkg::REQ_READ, 11'd513,  11'd0, 64'h0);
		send_item(prapq_pkg::REQ_READ, 11'd1,    11'd0, 64'h0);
		for (int i = 0; i < 120; i++) random_item();

		// size sweep, extremes included; tags and elements carry over each change
		sizes = '{1, 1024, 0, 2047, 7, 2, 513, $urandom_range(1, 1024)};
		foreach (sizes[s]) begin
			settle();
			write_size(11'(sizes[s]));
			for (int i = 0; i < ((sizes[s] == 0) ? 20 : 120); i++) random_item();
		end

		settle();
		if (tree_model.expected_reads.size() != 0) begin
			$display("%0t: %0d read results never arrived", $time,
				 tree_model.expected_reads.size());
			tree_model.errors++;
		end
		$display("Covered %0d request items over %0d size settings (0, 1, 1024, 2047 among them)",
			 items_sent, sizes_used.size());
		$display("%0d read results compared, %0d errors", tree_model.reads_checked,
			 tree_model.errors);
		if (tree_model.errors == 0)
			$display("tb_progression_range_add_point_query passed");
		else
			$display("tb_progression_range_add_point_query failed");
		$finish;
	end

endmodule
